FILE: rtl/wma_pkg.sv
`timescale 1ns / 1ps

package wma_pkg;

    // APB register map
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;
    localparam logic [PADDR_W-1:0] ADDR_WINDOW_SIZE = 2'd0;

    // window_size register field
    localparam int CFG_WIN_W = 7;
    localparam int WIN_RESET = 16;

endpackage

FILE: rtl/wma_if.sv
`timescale 1ns / 1ps

// Input channel: one signed sample per word.
interface wma_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Output channel: average and window-full flag per word.
interface wma_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] average;
    logic                           window_full;

    modport source (output valid, output average, output window_full, input ready);
    modport sink   (input valid, input average, input window_full, output ready);
endinterface

FILE: rtl/wma_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module wma_div #(
    parameter int SUM_W = 22,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_q;

    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_fits;

    always_comb begin
        w_trial = {r_rem, r_q[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fits  = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SUM_W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                // shift in the next dividend bit, keep the partial remainder
                r_rem <= w_fits ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/windowed_moving_average.sv
`timescale 1ns / 1ps
// Flow: an accepted word passes READ, ADD, SUB (only once the window is full), DIV, WAIT and OUT;
//   WAIT lasts while the divider works (one bit a cycle).
// The block takes no new word until the last one has left OUT, which waits for a free output
//   register; the input is ready only in the idle state.
// Reset: synchronous active low; window_size returns to 16 (capped at MAX_WINDOW),
//   and pointer, fill count and sum clear. The sample ring is not cleared.

// Moving average over the last window_size samples, kept as a running sum.
// Each word walks a small sequencer:
//   IDLE  - take the sample, latch the ring slot
//   READ  - fetch the sample about to be overwritten (registered memory read)
//   ADD   - add the new sample, write it into the ring, advance pointer and count
//   SUB   - subtract the overwritten sample (only once the window is full)
//   DIV   - start the divider on |sum| / fill_count
//   WAIT  - hold until the quotient is ready
//   OUT   - restore the sign, load the output register when it is free
// The ring needs no clearing: after a window_size write the slots are refilled
// in order, and an old sample is only subtracted once the window is full.
module windowed_moving_average #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wma_pkg::PADDR_W-1:0]  paddr,
    input  logic [wma_pkg::PDATA_W-1:0]  pwdata,
    output logic [wma_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,

    // data channels
    wma_in_if.sink                       i_in,
    wma_out_if.source                    o_out
);

    // ring index, count / window width, and running sum width
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
    localparam int WIN_INIT = (wma_pkg::WIN_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                                : wma_pkg::WIN_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_SUB,
        S_DIV,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_win;
    logic [CNT_W-1:0]                r_fill;
    logic [AW-1:0]                   r_wp;
    logic [AW-1:0]                   r_slot;
    logic signed [SUM_W-1:0]         r_sum;
    logic signed [SAMPLE_WIDTH-1:0]  r_sample;
    logic signed [SAMPLE_WIDTH-1:0]  r_old;
    logic                            r_neg;
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_out_avg;
    logic                            r_out_full;

    // sample ring
    logic signed [SAMPLE_WIDTH-1:0]  r_store [MAX_WINDOW];

    logic                            w_cfg_wr;
    logic [wma_pkg::CFG_WIN_W-1:0]   w_cfg_val;
    logic [CNT_W-1:0]                w_slot_inc;
    logic [SUM_W-1:0]                w_mag;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [SUM_W-1:0]                w_quot;
    logic [SAMPLE_WIDTH-1:0]         w_q_lo;
    logic                            w_out_free;

    assign pready    = 1'b1;
    assign prdata    = wma_pkg::PDATA_W'(r_win);
    assign w_cfg_wr  = psel && penable && pwrite && (paddr == wma_pkg::ADDR_WINDOW_SIZE);
    assign w_cfg_val = pwdata[wma_pkg::CFG_WIN_W-1:0];

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.average     = r_out_avg;
    assign o_out.window_full = r_out_full;

    always_comb begin
        w_slot_inc  = CNT_W'(r_slot) + 1'b1;
        w_mag       = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_div_start = (r_state == S_DIV);
        w_q_lo      = w_quot[SAMPLE_WIDTH-1:0];
        w_out_free  = !r_out_valid || o_out.ready;
    end

    wma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // ring memory: registered read of the slot to be overwritten, write of the new sample
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_old <= r_store[r_slot];
        end
        if (r_state == S_ADD) begin
            r_store[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= CNT_W'(WIN_INIT);
            r_fill      <= '0;
            r_wp        <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output word once taken
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sample <= i_in.sample;
                        // guard a pointer past the window
                        r_slot   <= (CNT_W'(r_wp) >= r_win) ? '0 : r_wp;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum <= r_sum + SUM_W'(r_sample);
                    r_wp  <= (w_slot_inc >= r_win) ? '0 : AW'(w_slot_inc);
                    if (r_fill < r_win) begin
                        r_fill  <= r_fill + 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_sum   <= r_sum - SUM_W'(r_old);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_neg ? -$signed(w_q_lo) : $signed(w_q_lo);
                        r_out_full  <= (r_fill == r_win);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // window_size write: saturate, keep size on zero, always clear the window
            if (w_cfg_wr) begin
                if (32'(w_cfg_val) > MAX_WINDOW) begin
                    r_win <= CNT_W'(MAX_WINDOW);
                end else if (w_cfg_val != '0) begin
                    r_win <= CNT_W'(w_cfg_val);
                end
                r_fill <= '0;
                r_wp   <= '0;
                r_sum  <= '0;
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

// Moving-average bench: drives samples through the input channel, mirrors the
// running-sum window in a local predictor and checks every output word
// against it. The window size register is exercised over the APB port,
// including the zero-write and saturation cases.
module tb;

    localparam int SAMPLE_W      = 16;
    localparam int MAX_WIN       = 64;
    // Margin beyond the DUT latency before touching config.
    localparam int SETTLE_CYCLES = 40;
    localparam int TARGET_WORDS  = 1050;
    // Stop idling on both sides once this many words have gone in.
    localparam int CALM_WORDS    = 850;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef enum int {
        MIX_FULL_RANGE,
        MIX_EXTREMES,
        MIX_NEAR_ZERO,
        MIX_ALL_MIN,
        MIX_ALL_MAX
    } t_sample_mix;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic                       window_full;
    } t_avg_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [wma_pkg::PADDR_W-1:0]  paddr;
    logic [wma_pkg::PDATA_W-1:0]  pwdata;
    logic [wma_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    wma_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
    wma_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_if ();

    windowed_moving_average #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Predictor state: a copy of the ring, its pointer, fill count and sum.
    logic signed [SAMPLE_W-1:0] window_ring [MAX_WIN];
    int                         ring_slot;
    int                         held_count;
    int                         window_sum;
    int                         window_len;

    t_avg_word   pending_averages [$];
    t_avg_word   want_word;
    int unsigned words_sent;
    int unsigned mismatches;
    bit          idle_on;
    int unsigned stall_left;

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop: far beyond the slowest legal run (every word waiting out the
    // longest gap, the longest stall and the full divider latency).
    initial begin
        #5_000_000;
        $display("[windowed_moving_average] ERROR");
        $finish;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Mirror a window_size write: zero keeps the size, oversize saturates,
    // and every write empties the window.
    function automatic void apply_window_write(input logic [wma_pkg::CFG_WIN_W-1:0] value);
        if (value > MAX_WIN)
            window_len = MAX_WIN;
        else if (value != 0)
            window_len = int'(value);
        ring_slot  = 0;
        held_count = 0;
        window_sum = 0;
    endfunction

    // Advance the window by one sample and return the word it must produce.
    function automatic t_avg_word predict_average(input logic signed [SAMPLE_W-1:0] value);
        t_avg_word w;
        int        slot;
        int        quotient;
        slot = (ring_slot >= window_len) ? 0 : ring_slot;
        if (held_count < window_len) begin
            window_sum += value;
            held_count++;
        end else begin
            // Window full: drop the oldest sample before adding the new one.
            window_sum = window_sum - window_ring[slot] + value;
        end
        window_ring[slot] = value;
        ring_slot = (slot + 1 >= window_len) ? 0 : slot + 1;
        // Signed int division truncates toward zero, as the block must.
        quotient      = window_sum / held_count;
        w.average     = quotient[SAMPLE_W-1:0];
        w.window_full = (held_count == window_len);
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input t_sample_mix mix);
        case (mix)
            MIX_EXTREMES: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return 16'sh0000;
                    default: return -16'sh0001;
                endcase
            end
            MIX_NEAR_ZERO: return $signed(16'($urandom_range(0, 16))) - 16'sd8;
            MIX_ALL_MIN:   return SAMPLE_MIN;
            MIX_ALL_MAX:   return SAMPLE_MAX;
            default:       return $signed(16'($urandom));
        endcase
    endfunction

    // Send one word; called and returning at a falling edge. Valid is left
    // high on return: the next call or drain_results decides what it becomes,
    // so each edge sees at most one update of it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= value;
        do @(posedge i_clk); while (!in_if.ready);
        pending_averages.push_back(predict_average(value));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_averages.size() != 0);
    endtask

    // Make the block idle before a register access.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup, then access; the register takes it at the access edge.
    task automatic write_window(input logic [wma_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= wma_pkg::ADDR_WINDOW_SIZE;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_window_write(data[wma_pkg::CFG_WIN_W-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Return to idle before the next transfer so back-to-back transfers never collide.
        @(negedge i_clk);
    endtask

    // APB read of window_size, checked against the predictor's copy.
    task automatic check_window_readback();
        logic [wma_pkg::PDATA_W-1:0] got;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= wma_pkg::ADDR_WINDOW_SIZE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got != wma_pkg::PDATA_W'(window_len))
            report_mismatch("window_size readback", int'(got), window_len);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Output side: stall in random bursts while idling is on, else take
    // every word.
    always @(negedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left != 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_averages.size() == 0) begin
                report_mismatch("unexpected output word", int'(out_if.average), 0);
            end else begin
                want_word = pending_averages.pop_front();
                if (out_if.average !== want_word.average)
                    report_mismatch("average", int'(out_if.average),
                                    int'(want_word.average));
                if (out_if.window_full !== want_word.window_full)
                    report_mismatch("window_full", int'(out_if.window_full),
                                    int'(want_word.window_full));
            end
        end
    end

    // Default size after reset: fill with extremes, including sums that
    // truncate toward zero from the negative side.
    task automatic test_reset_window();
        check_window_readback();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd3);
    endtask

    // Register cases: size one, saturation, zero write, ignored upper bits,
    // and a small window wrapping over extreme samples.
    task automatic test_window_writes();
        settle();
        write_window(32'd1);
        check_window_readback();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);

        // Oversize values saturate at the ring depth.
        settle();
        write_window(32'd200);
        check_window_readback();
        write_window(32'd65);
        check_window_readback();
        write_window(32'd127);
        check_window_readback();

        // Zero keeps the size but still empties the window.
        write_window(32'd0);
        check_window_readback();
        send_sample(-16'sd5);

        // Upper data bits are outside the field.
        settle();
        write_window(32'hffff_ff83);
        check_window_readback();
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);

        settle();
        write_window(32'd0);
        check_window_readback();
        send_sample(16'sd1);
        send_sample(-16'sd2);
    endtask

    // Random phases: pick a size, stream samples of one mix, sometimes pause
    // the sender until every expected word is back.
    task automatic test_random_streams();
        logic [wma_pkg::PDATA_W-1:0] cfg;
        t_sample_mix                 mix;
        int unsigned                 phase_len;
        while (words_sent < TARGET_WORDS) begin
            settle();
            case ($urandom_range(0, 6))
                0:       cfg = 32'd1;
                1:       cfg = MAX_WIN;
                2:       cfg = 32'd2;
                3:       cfg = $urandom_range(MAX_WIN + 1, 127);
                4:       cfg = 32'd0;
                5:       cfg = $urandom_range(1, 8);
                default: cfg = $urandom_range(1, MAX_WIN);
            endcase
            cfg[wma_pkg::PDATA_W-1:wma_pkg::CFG_WIN_W] =
                (wma_pkg::PDATA_W - wma_pkg::CFG_WIN_W)'($urandom);
            write_window(cfg);
            check_window_readback();

            idle_on   = (words_sent < CALM_WORDS) && ($urandom_range(0, 3) != 0);
            mix       = t_sample_mix'($urandom_range(0, 4));
            phase_len = $urandom_range(1, 2 * window_len + 4);
            repeat (phase_len) begin
                if (words_sent >= CALM_WORDS)
                    idle_on = 1'b0;
                send_sample(pick_sample(mix));
                if ($urandom_range(0, 63) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        // Drive every input to a known value before the first edge.
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        out_if.ready = 1'b0;
        idle_on      = 1'b0;
        stall_left   = 0;
        words_sent   = 0;
        mismatches   = 0;
        window_len   = (wma_pkg::WIN_RESET > MAX_WIN) ? MAX_WIN : wma_pkg::WIN_RESET;
        ring_slot    = 0;
        held_count   = 0;
        window_sum   = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_window();
        test_window_writes();
        test_random_streams();

        idle_on = 1'b0;
        settle();
        if (mismatches == 0)
            $display("[windowed_moving_average] OK");
        else
            $display("[windowed_moving_average] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/wma_pkg.sv
rtl/wma_if.sv
rtl/wma_div.sv
rtl/windowed_moving_average.sv
bench/tb.sv
